// ----- hdl/step_response_monitor_assert.svh -----
// Assertion macros shared by the step response monitor RTL.
`ifndef STEP_RESPONSE_MONITOR_ASSERT_SVH
`define STEP_RESPONSE_MONITOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/srm_pkg.sv -----
// Types and constants of the step response monitor.
package srm_pkg;

    localparam int SETTLE_DEPTH = 10;
    localparam int MODE_DEPTH   = 10;
    localparam int WIN_PTR_W    = $clog2(SETTLE_DEPTH);
    localparam int MODE_PTR_W   = $clog2(MODE_DEPTH);

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_DATA_W  = 14;

    localparam logic signed [15:0] WIN_FILL   = -16'sd2560;
    localparam logic signed [15:0] PEAK_INIT  = -16'sd32768;
    localparam logic signed [15:0] TROUGH_INIT = 16'sd32767;
    localparam logic [13:0]        COUNT_MAX  = 14'd10000;
    localparam logic [22:0]        OVS_MAX    = 23'h7FFFFF;
    localparam logic [23:0]        OVS_INIT   = 24'hFFFF00;
    localparam logic [23:0]        SETTLE_INIT = 24'hFFFFFF;
    localparam logic [6:0]         PCT_INIT   = 7'd10;
    localparam logic [13:0]        CAP_INIT   = 14'd1000;

    // Microseconds to milliseconds: ((t >> 3) * MS_RECIP) >> MS_SHIFT equals t / 1000.
    localparam logic [29:0] MS_RECIP = 30'd549755814;
    localparam int          MS_SHIFT = 36;
    localparam int          PROD_W   = 59;

    localparam logic [14:0] OVS_SCALE = 15'd25600;
    localparam logic [6:0]  PCT_SCALE = 7'd100;
    localparam int          DIV_BITS  = 25;
    localparam int          DIV_CNT_W = $clog2(DIV_BITS);
    localparam int          UNIT_W    = 40;

    typedef enum logic [0:0] {
        CFG_SETTLE_PCT = 1'b0,
        CFG_SAMPLE_CAP = 1'b1
    } t_cfg_index;

    typedef enum logic [0:0] {
        ACT_COMMAND = 1'b0,
        ACT_SAMPLE  = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_SETTLE,
        ST_WRAP,
        ST_DONE
    } t_state;

endpackage

// ----- hdl/step_response_monitor.sv -----
// Step response monitor: rise time, settling time and overshoot of a speed loop.
//
// Items arrive on the s_axis channel; tuser carries the action (command or sample)
// and tdata the event time, setpoint, speed and drive-mode flag. Every item yields
// exactly one result transfer on m_axis, reporting the state after that item.
// Settings are written through the cfg channel, which is ready whenever reset is
// released and must be used only while the block is idle.
// A command updates the step state and goes straight to its result. A sample uses
// one shared 40-bit subtract-compare unit: it runs the 25-step overshoot division
// when the extreme moves and neither target nor speed is zero, then checks up to
// ten window entries against the settling band.
// s_axis_tready is high only in the idle state; the block takes the next item
// while its last result still waits in the output register.
// If the receiver stalls, a finished result holds the sequencer before it loads
// the output register, so no result is lost or reordered.
// Reset is synchronous and active low; it restores all settings and measurement
// state, after which the block is ready at once.

`include "step_response_monitor_assert.svh"

module step_response_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // time_us[31:0], setpoint_q8[47:32], speed_q8[63:48], mode_off[64], zero fill
    input  logic [srm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // action[0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rise_time_ms[22:0], settling_time_ms[46:23], overshoot_now[70:47],
    // overshoot_final[94:71], plot_enable[95]
    output logic [srm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [0:0]                        i_cfg_index,
    input  logic [srm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import srm_pkg::*;

    function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? (~d + 17'd1) : d;
    endfunction

    t_state n_state, r_state;

    logic [6:0]  r_settle_pct;
    logic [13:0] r_sample_cap;

    t_action            r_action;
    logic [31:0]        r_time;
    logic signed [15:0] r_setpoint;
    logic signed [15:0] r_speed;
    logic               r_mode_off;

    logic signed [15:0]   r_target;
    logic signed [15:0]   r_prior;
    logic [31:0]          r_step_start;
    logic signed [15:0]   r_win [SETTLE_DEPTH];
    logic [WIN_PTR_W-1:0] r_win_pos;
    logic signed [15:0]   r_peak;
    logic signed [15:0]   r_trough;
    logic [23:0]          r_ovs_cur;
    logic [23:0]          r_ovs_lat;
    logic [22:0]          r_rise_res;
    logic [23:0]          r_settle_res;
    logic                 r_rise_armed;
    logic                 r_settle_done;
    logic [13:0]          r_count;
    logic [MODE_DEPTH-1:0] r_mode_win;
    logic [MODE_PTR_W-1:0] r_mode_pos;

    logic [PROD_W-1:0]    r_prod;
    logic                 r_rise_hit;
    logic                 r_div_run;
    logic                 r_neg;
    logic [31:0]          r_rem;
    logic [UNIT_W-1:0]    r_dsor;
    logic [DIV_BITS-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_settle_chk;
    logic                 r_settle_fail;
    logic [WIN_PTR_W-1:0] r_chk_idx;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [15:0]        abs_tgt;
    logic [16:0]        dev_speed;
    logic [31:0]        ovs_num;
    logic               in_cap;
    logic               peak_upd;
    logic               trough_upd;
    logic               div_start;
    logic               chk_start;
    logic signed [20:0] s10;
    logic signed [20:0] t9;
    logic signed [20:0] t11;
    logic               crossed;
    logic [31:0]        dt;
    logic [22:0]        elapsed;
    logic [16:0]        dev_win;
    logic [22:0]        band_lhs;
    logic [23:0]        band_rhs;
    logic [UNIT_W-1:0]  u_a;
    logic [UNIT_W-1:0]  u_b;
    logic [UNIT_W:0]    u_diff;
    logic               u_ge;
    logic               out_load;
    logic [22:0]        ovs_mag;
    logic [23:0]        ovs_ext;
    logic [23:0]        ovs_div;

    assign o_cfg_ready   = i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign abs_tgt    = r_target[15] ? (~r_target + 16'd1) : r_target;
    assign dev_speed  = abs_diff(r_speed, r_target);
    assign ovs_num    = 32'(dev_speed) * 32'(OVS_SCALE);
    assign in_cap     = r_count <= r_sample_cap;
    assign peak_upd   = (r_prior <= r_target) && in_cap && (r_speed >= r_peak);
    assign trough_upd = (r_prior > r_target) && in_cap && (r_speed <= r_trough);
    assign div_start  = (peak_upd || trough_upd) && (r_target != 16'sd0)
                        && (r_speed != 16'sd0);
    assign chk_start  = !r_settle_done && (r_target != 16'sd0);

    assign s10 = $signed({{5{r_speed[15]}}, r_speed}) * 21'sd10;
    assign t9  = $signed({{5{r_target[15]}}, r_target}) * 21'sd9;
    assign t11 = $signed({{5{r_target[15]}}, r_target}) * 21'sd11;
    assign crossed = ((r_prior < r_target) && (s10 > t9))
                     || ((r_prior > r_target) && (s10 < t11));

    assign dt      = r_time - r_step_start;
    assign elapsed = r_prod[PROD_W-1:MS_SHIFT];

    assign dev_win  = abs_diff(r_win[r_chk_idx], r_target);
    assign band_lhs = 23'(r_settle_pct) * 23'(abs_tgt);
    assign band_rhs = 24'(dev_win) * 24'(PCT_SCALE);

    assign u_diff = {1'b0, u_a} - {1'b0, u_b};
    assign u_ge   = ~u_diff[UNIT_W];

    assign ovs_mag = (r_quo[DIV_BITS-1] || r_quo[DIV_BITS-2]) ? OVS_MAX : r_quo[22:0];
    assign ovs_ext = {1'b0, ovs_mag};
    assign ovs_div = r_neg ? (~ovs_ext + 24'd1) : ovs_ext;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_action == ACT_COMMAND) begin
                    n_state = ST_DONE;
                end else if (div_start) begin
                    n_state = ST_DIV;
                end else if (chk_start) begin
                    n_state = ST_SETTLE;
                end else begin
                    n_state = ST_WRAP;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = r_settle_chk ? ST_SETTLE : ST_WRAP;
                end
            end
            ST_SETTLE: begin
                if (!u_ge || (r_chk_idx == WIN_PTR_W'(SETTLE_DEPTH - 1))) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        u_a           = UNIT_W'(band_lhs);
        u_b           = UNIT_W'(band_rhs);
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = i_rst_n;
            end
            ST_DIV: begin
                u_a = UNIT_W'(r_rem);
                u_b = r_dsor;
            end
            ST_DONE: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_settle_pct  <= PCT_INIT;
            r_sample_cap  <= CAP_INIT;
            r_target      <= '0;
            r_prior       <= '0;
            r_step_start  <= '0;
            for (int k = 0; k < SETTLE_DEPTH; k++) begin
                r_win[k] <= WIN_FILL;
            end
            r_win_pos     <= '0;
            r_peak        <= PEAK_INIT;
            r_trough      <= TROUGH_INIT;
            r_ovs_cur     <= OVS_INIT;
            r_ovs_lat     <= '0;
            r_rise_res    <= '0;
            r_settle_res  <= SETTLE_INIT;
            r_rise_armed  <= 1'b0;
            r_settle_done <= 1'b0;
            r_count       <= '0;
            r_mode_win    <= '0;
            r_mode_pos    <= '0;
            r_rise_hit    <= 1'b0;
            r_div_run     <= 1'b0;
            r_settle_chk  <= 1'b0;
            r_settle_fail <= 1'b0;
            r_chk_idx     <= '0;
            r_div_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_SETTLE_PCT: r_settle_pct <= i_cfg_data[6:0];
                    CFG_SAMPLE_CAP: r_sample_cap <= i_cfg_data;
                    default: r_sample_cap <= r_sample_cap;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_EXEC: begin
                    if (r_action == ACT_COMMAND) begin
                        r_prior       <= r_target;
                        r_target      <= r_setpoint;
                        r_step_start  <= r_time;
                        for (int k = 0; k < SETTLE_DEPTH; k++) begin
                            r_win[k] <= WIN_FILL;
                        end
                        r_win_pos     <= '0;
                        r_peak        <= PEAK_INIT;
                        r_trough      <= TROUGH_INIT;
                        r_rise_res    <= '0;
                        r_count       <= '0;
                        r_settle_done <= 1'b0;
                        r_rise_armed  <= 1'b1;
                        r_ovs_lat     <= r_ovs_cur;
                        r_rise_hit    <= 1'b0;
                        r_div_run     <= 1'b0;
                        r_settle_chk  <= 1'b0;
                    end else begin
                        r_mode_win[r_mode_pos] <= r_mode_off;
                        r_mode_pos <= (r_mode_pos == MODE_PTR_W'(MODE_DEPTH - 1))
                                      ? '0 : r_mode_pos + 1'b1;
                        if (peak_upd) begin
                            r_peak <= r_speed;
                        end
                        if (trough_upd) begin
                            r_trough <= r_speed;
                        end
                        if (peak_upd || trough_upd) begin
                            if (r_target == 16'sd0) begin
                                r_ovs_cur <= {1'b0, OVS_MAX};
                            end else if (r_speed == 16'sd0) begin
                                r_ovs_cur <= '0;
                            end
                        end
                        r_div_run  <= div_start;
                        r_div_cnt  <= DIV_CNT_W'(DIV_BITS - 1);
                        r_rise_hit <= r_rise_armed && crossed;
                        if (r_rise_armed && crossed) begin
                            r_rise_armed <= 1'b0;
                        end
                        r_win[r_win_pos] <= r_speed;
                        r_win_pos <= (r_win_pos == WIN_PTR_W'(SETTLE_DEPTH - 1))
                                     ? '0 : r_win_pos + 1'b1;
                        if (r_count < COUNT_MAX) begin
                            r_count <= r_count + 14'd1;
                        end
                        r_settle_chk  <= chk_start;
                        r_settle_fail <= 1'b0;
                        r_chk_idx     <= '0;
                    end
                end
                ST_DIV: begin
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
                ST_SETTLE: begin
                    if (!u_ge) begin
                        r_settle_fail <= 1'b1;
                    end
                    r_chk_idx <= r_chk_idx + 1'b1;
                end
                ST_WRAP: begin
                    if (r_div_run) begin
                        r_ovs_cur <= ovs_div;
                    end
                    r_div_run <= 1'b0;
                    if (r_rise_hit) begin
                        r_rise_res <= elapsed;
                    end
                    if (r_settle_chk && !r_settle_fail) begin
                        r_settle_res  <= {1'b0, elapsed};
                        r_settle_done <= 1'b1;
                    end
                end
                default: begin
                    r_chk_idx <= r_chk_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_action   <= t_action'(s_axis_tuser[0]);
            r_time     <= s_axis_tdata[31:0];
            r_setpoint <= s_axis_tdata[47:32];
            r_speed    <= s_axis_tdata[63:48];
            r_mode_off <= s_axis_tdata[64];
        end
        if (r_state == ST_EXEC) begin
            r_prod  <= PROD_W'(dt[31:3]) * PROD_W'(MS_RECIP);
            r_rem   <= ovs_num;
            r_dsor  <= {abs_tgt, 24'd0};
            r_quo   <= '0;
            r_neg   <= r_target[15];
        end else if (r_state == ST_DIV) begin
            if (u_ge) begin
                r_rem <= u_diff[31:0];
            end
            r_quo  <= {r_quo[DIV_BITS-2:0], u_ge};
            r_dsor <= r_dsor >> 1;
        end
        if (out_load) begin
            r_out_data <= {~&r_mode_win, r_ovs_lat, r_ovs_cur, r_settle_res, r_rise_res};
        end
    end

    `SRM_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, r_state == ST_EXEC, "accept lost")
    `SRM_ASSERT_NEXT(a_load_valid, out_load, m_axis_tvalid, "result not presented")
    `SRM_ASSERT_SAME(a_settle_result, r_settle_done, r_settle_res != SETTLE_INIT, "no settling time")
    `SRM_ASSERT_SAME(a_check_armed, r_state == ST_SETTLE, r_settle_chk, "window check not armed")

endmodule
